// File: src/sha1_pkg.sv
// Shared types and constants for the SHA-1 digest block.
`default_nettype none
package sha1_pkg;
   // Entry passed from front (intake) to back (compression engine)
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } item_type;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_POS = 6'd56;
endpackage
`default_nettype wire

// File: src/sha1_message_digest.sv
// Top level of the SHA-1 digest block: intake queue and compression engine.
//   channel   direction  handshake
//   req_      in         req_valid / req_stall, one byte item per transfer
//   rsp_      out        rsp_valid / rsp_stall, one digest word per transfer
// The engine takes a byte while idle; a full block then runs load, rounds and add.
// Finalizing pads, loads, runs the rounds and adds (twice when two padding blocks
// are needed), passes an idle state, then gives one word per cycle while rsp_stall is low.
// Reset is synchronous, active high, and restores the initial chaining words.
// A four-entry queue takes bytes while the engine is busy or the output stalls.
`default_nettype none
module sha1_message_digest
   import sha1_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   output logic             rsp_too_long
);
   item_type wr_item, rd_item;
   logic     rd_valid, rd_take;

   assign wr_item = '{data_byte: req_data_byte, byte_valid: req_byte_valid,
                      end_of_message: req_end_of_message};

   sha1_fifo u_fifo (
      .clock, .reset, .req_valid, .req_stall, .wr_item,
      .rd_valid, .rd_take, .rd_item
   );

   sha1_engine u_engine (
      .clock, .reset, .in_valid(rd_valid), .in_take(rd_take), .in_item(rd_item),
      .rsp_valid, .rsp_stall, .rsp_digest_word, .rsp_word_index,
      .rsp_last_word, .rsp_too_long
   );
endmodule
`default_nettype wire

// File: src/sha1_fifo.sv
// Short queue between intake and compression engine.
`default_nettype none
module sha1_fifo
   import sha1_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire item_type wr_item,
   output logic          rd_valid,
   input  wire logic     rd_take,
   output item_type      rd_item
);
   item_type   mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_stall = (cnt_ff == 3'd4);
   assign push      = req_valid && !req_stall;
   assign rd_valid  = (cnt_ff != 3'd0);
   assign pop       = rd_valid && rd_take;
   assign rd_item   = mem_ff[rp_ff];

   // advance pointers and occupancy
   always_comb begin
      wp_in  = push ? wp_ff + 2'd1 : wp_ff;
      rp_in  = pop ? rp_ff + 2'd1 : rp_ff;
      cnt_in = cnt_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_item;
   end
endmodule
`default_nettype wire

// File: src/sha1_engine.sv
// Back end: byte buffer, padding, 80-round compression and digest output.
`default_nettype none
module sha1_engine
   import sha1_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_take,
   input  wire item_type in_item,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic [31:0]   rsp_digest_word,
   output logic [2:0]    rsp_word_index,
   output logic          rsp_last_word,
   output logic          rsp_too_long
);
   localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_ROUND = 3'd2,
                          S_ADD = 3'd3, S_PAD = 3'd4, S_OUT = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [31:0] wbuf_ff [16];         // block as 16 words
   logic [31:0] wsch_ff [16];         // schedule window
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  rnd_ff;
   logic [5:0]  fill_ff;
   logic [63:0] len_ff;
   logic        ovf_ff;
   logic        eom_ff;              // finalizing in progress
   logic [1:0]  padph_ff;            // 0 none,1 second block pending,2 last done
   logic [2:0]  oidx_ff;
   logic        flag_out_ff;

   logic [31:0] f, k, t, wnew, wcur;
   logic [63:0] len_add;
   logic        store;
   logic        len_fit;

   assign len_add = len_ff + 64'd8;
   assign store   = in_item.byte_valid && !ovf_ff;
   assign in_take = (st_ff == S_IDLE) && !eom_ff;
   assign len_fit = (padph_ff == 2'd1) || (fill_ff < LEN_POS);

   // round function
   always_comb begin
      wcur = wsch_ff[0];
      wnew = {wsch_ff[13] ^ wsch_ff[8] ^ wsch_ff[2] ^ wsch_ff[0]};
      wnew = {wnew[30:0], wnew[31]};
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + wcur + k;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE:  st_in = S_IDLE;
         S_LOAD:  st_in = S_ROUND;
         S_ROUND: st_in = (rnd_ff == 7'd79) ? S_ADD : S_ROUND;
         S_ADD:   st_in = S_IDLE;
         S_PAD:   st_in = S_LOAD;
         S_OUT:   st_in = S_OUT;
         default: st_in = S_IDLE;
      endcase
   end

   assign rsp_valid       = (st_ff == S_OUT);
   assign rsp_word_index  = oidx_ff;
   assign rsp_too_long    = flag_out_ff;
   assign rsp_last_word   = flag_out_ff || (oidx_ff == 3'd4);
   assign rsp_digest_word = flag_out_ff ? 32'd0 : h_ff[oidx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; fill_ff <= '0; len_ff <= '0; ovf_ff <= 1'b0;
         eom_ff <= 1'b0; padph_ff <= '0; oidx_ff <= '0; flag_out_ff <= 1'b0;
         rnd_ff <= '0;
         h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
         h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (eom_ff) begin
                  // finish padding before taking the next transfer
                  st_ff <= (padph_ff == 2'd2) ? S_OUT : S_PAD;
                  oidx_ff <= '0; flag_out_ff <= 1'b0;
               end else if (in_valid) begin
                  // store byte, count length, start block or finalize, or flag an overlong message
                  if (store) begin
                     wbuf_ff[fill_ff[5:2]] <= (fill_ff[1:0] == 2'd0) ?
                        {in_item.data_byte, 24'd0} :
                        wbuf_ff[fill_ff[5:2]] |
                        ({24'd0, in_item.data_byte} << {~fill_ff[1:0], 3'd0});
                     fill_ff <= fill_ff + 6'd1;
                     len_ff  <= len_add;
                     if (len_add == 64'd0) ovf_ff <= 1'b1;
                  end
                  eom_ff <= in_item.end_of_message;
                  if (in_item.end_of_message && (ovf_ff || (store && len_add == 64'd0)))
                  begin
                     flag_out_ff <= 1'b1; oidx_ff <= '0; st_ff <= S_OUT;
                  end else if (store && fill_ff == 6'd63) begin
                     st_ff <= S_LOAD;
                  end else if (in_item.end_of_message) begin
                     st_ff <= S_PAD;
                  end
               end
            end
            S_PAD: begin
               // pad the current block; length goes in if it fits
               for (int i = 0; i < 16; i++) begin
                  logic [31:0] wv;
                  wv = wbuf_ff[i];
                  if (padph_ff == 2'd1) wv = 32'd0;
                  else begin
                     for (int j = 0; j < 4; j++) begin
                        if (6'(4*i+j) == fill_ff)
                           wv[31-8*j -: 8] = PAD_BYTE;
                        else if (6'(4*i+j) > fill_ff)
                           wv[31-8*j -: 8] = 8'd0;
                     end
                     if (4*i >= 4*(fill_ff[5:2]) + 4) wv = 32'd0;
                  end
                  if (len_fit && i == 14) wv = len_ff[63:32];
                  if (len_fit && i == 15) wv = len_ff[31:0];
                  wbuf_ff[i] <= wv;
               end
               if (len_fit) begin
                  padph_ff <= 2'd2;
               end else begin
                  padph_ff <= 2'd1;
               end
               st_ff <= S_LOAD;
            end
            S_LOAD: begin
               for (int i = 0; i < 16; i++) wsch_ff[i] <= wbuf_ff[i];
               a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
               d_ff <= h_ff[3]; e_ff <= h_ff[4];
               rnd_ff <= '0; fill_ff <= '0;
               st_ff <= st_in;
            end
            S_ROUND: begin
               for (int i = 0; i < 15; i++) wsch_ff[i] <= wsch_ff[i+1];
               wsch_ff[15] <= wnew;
               e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
               b_ff <= a_ff; a_ff <= t;
               rnd_ff <= rnd_ff + 7'd1;
               st_ff <= st_in;
            end
            S_ADD: begin
               h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
               h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
               h_ff[4] <= h_ff[4] + e_ff;
               st_ff <= S_IDLE;
            end
            S_OUT: begin
               // hand out words, then return to reset values
               if (!rsp_stall) begin
                  if (rsp_last_word) begin
                     st_ff <= S_IDLE; fill_ff <= '0; len_ff <= '0; ovf_ff <= 1'b0;
                     eom_ff <= 1'b0; padph_ff <= '0; flag_out_ff <= 1'b0;
                     oidx_ff <= '0;
                     h_ff[0] <= H0_INIT; h_ff[1] <= H1_INIT; h_ff[2] <= H2_INIT;
                     h_ff[3] <= H3_INIT; h_ff[4] <= H4_INIT;
                  end else begin
                     oidx_ff <= oidx_ff + 3'd1;
                  end
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
